/* sv/hst_pkg.sv */
// Shared types, constants and the arctangent table of the sprite transform core.
`default_nettype none
package hst_pkg;
   localparam int NodeCountDefault = 256;
   localparam int CoordBitsDefault = 16;
   localparam int CordicSteps = 16;
   localparam logic [15:0] CordicK = 16'd39797;
   localparam logic [23:0] ScaleMax = 24'hFFFFFF;

   // command from controller to datapath
   typedef struct packed {
      logic load;      // latch request and start table read
      logic compose;   // form scales and angle
      logic offset;    // form unrotated offsets from composed scales
      logic rot_init;  // apply quarter turns and gain
      logic rot_step;  // one CORDIC iteration
      logic finish;    // form origin and outputs
      logic commit;    // write table and load result register
   } cmd_type;

   typedef struct packed {
      logic last_step;
   } stat_type;

   function automatic logic [31:0] atan_entry(input logic [3:0] i);
      logic [31:0] r;
      begin
         case (i)
            4'd0: r = 32'd536870912;
            4'd1: r = 32'd316933406;
            4'd2: r = 32'd167458907;
            4'd3: r = 32'd85004756;
            4'd4: r = 32'd42667331;
            4'd5: r = 32'd21354465;
            4'd6: r = 32'd10679838;
            4'd7: r = 32'd5340245;
            4'd8: r = 32'd2670163;
            4'd9: r = 32'd1335087;
            4'd10: r = 32'd667544;
            4'd11: r = 32'd333772;
            4'd12: r = 32'd166886;
            4'd13: r = 32'd83443;
            4'd14: r = 32'd41722;
            default: r = 32'd20861;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

/* sv/hst_ctrl.sv */
// Sequencer of the sprite transform core: steps one request through the datapath.
`default_nettype none
module hst_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output hst_pkg::cmd_type      cmd,
   input  wire hst_pkg::stat_type stat
);
   import hst_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_READ    = 8'b00000010,
      S_COMPOSE = 8'b00000100,
      S_OFFSET  = 8'b00001000,
      S_INIT    = 8'b00010000,
      S_STEP    = 8'b00100000,
      S_FINISH  = 8'b01000000,
      S_COMMIT  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      valid_in = valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_COMPOSE;
         S_COMPOSE: begin
            cmd.compose = 1'b1;
            state_in = S_OFFSET;
         end
         S_OFFSET: begin
            cmd.offset = 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.rot_init = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.rot_step = 1'b1;
            if (stat.last_step) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // hold until the previous result is taken
            if (!valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

/* sv/hst_dpath.sv */
// Datapath of the sprite transform core: node table, scale compose, CORDIC and output formatting.
`default_nettype none
module hst_dpath #(
   parameter int NODE_COUNT = hst_pkg::NodeCountDefault,
   parameter int COORD_BITS = hst_pkg::CoordBitsDefault
) (
   input  wire logic              clock,
   input  wire hst_pkg::cmd_type  cmd,
   output hst_pkg::stat_type      stat,
   input  wire logic [7:0]        node_id,
   input  wire logic [7:0]        parent_id,
   input  wire logic              is_root,
   input  wire logic signed [15:0] pos_x,
   input  wire logic signed [15:0] pos_y,
   input  wire logic [23:0]       own_scale_w,
   input  wire logic [23:0]       own_scale_h,
   input  wire logic [15:0]       local_angle,
   input  wire logic [16:0]       center_frac_w,
   input  wire logic [16:0]       center_frac_h,
   input  wire logic [13:0]       texture_w,
   input  wire logic [13:0]       texture_h,
   output logic [15:0]            rect_x,
   output logic [15:0]            rect_y,
   output logic [15:0]            rect_w,
   output logic [15:0]            rect_h,
   output logic [15:0]            render_angle,
   output logic [15:0]            pivot_x,
   output logic [15:0]            pivot_y
);
   import hst_pkg::*;

   localparam int IdBits = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int EntryBits = 24 + 24 + 16 + 2 * COORD_BITS;
   // offset is a 16-bit position times up to 8 integer scale bits
   localparam int DBits = 26;
   // d*K adds 16 bits, CORDIC growth under 2 bits
   localparam int RotBits = DBits + 17;
   localparam int SrcBits = COORD_BITS + 42;
   localparam int OBits = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
   localparam int CoordHi = (1 << (COORD_BITS - 1)) - 1;

   logic [EntryBits-1:0] table_mem [NODE_COUNT];
   logic [EntryBits-1:0] rd_ff;

   logic [IdBits-1:0] id_ff, par_ff;
   logic              root_ff;
   logic signed [15:0] px_ff, py_ff;
   logic [23:0]       sw_ff, sh_ff;
   logic [15:0]       ang_ff;
   logic [16:0]       fw_ff, fh_ff;
   logic [13:0]       tw_ff, th_ff;

   logic [23:0] pscw, psch;
   logic [15:0] pang;
   logic signed [COORD_BITS-1:0] porx, pory;
   assign {pscw, psch, pang, porx, pory} = rd_ff;

   logic [23:0] cw_ff, ch_ff;
   logic signed [DBits-1:0] dx_ff, dy_ff;
   logic signed [RotBits-1:0] x_ff, y_ff;
   logic signed [31:0] z_ff;
   logic [3:0] step_ff;
   logic signed [OBits-1:0] ox_ff, oy_ff;
   logic [15:0] fang_ff;
   logic [15:0] rw_ff, rh_ff;

   function automatic logic signed [DBits-1:0] axis(
      input logic signed [COORD_BITS-1:0] porg, input logic signed [15:0] pos,
      input logic [23:0] sc);
      logic signed [SrcBits-1:0] s, q;
      begin
         s = (SrcBits'(porg) <<< 16) + SrcBits'(pos) * $signed({1'b0, sc});
         q = s >>> 16;
         if (s < 0 && s[15:0] != 16'd0) q = q + 1;
         return DBits'(q - SrcBits'(porg));
      end
   endfunction

   function automatic logic signed [COORD_BITS+1:0] org(
      input logic signed [COORD_BITS-1:0] porg, input logic signed [RotBits-1:0] r);
      logic signed [RotBits+COORD_BITS:0] s, q;
      logic signed [COORD_BITS+1:0] hi, lo, v;
      begin
         s = ((RotBits+COORD_BITS+1)'(porg) <<< 16) + (RotBits+COORD_BITS+1)'(r);
         q = s >>> 16;
         if (s < 0 && s[15:0] != 16'd0) q = q + 1;
         hi = (COORD_BITS+2)'(CoordHi);
         lo = -hi - 1;
         if (q > (RotBits+COORD_BITS+1)'(hi)) v = hi;
         else if (q < (RotBits+COORD_BITS+1)'(lo)) v = lo;
         else v = (COORD_BITS+2)'(q);
         return v;
      end
   endfunction

   function automatic logic [23:0] mscale(input logic [23:0] a, input logic [23:0] b);
      logic [47:0] p;
      begin
         p = a * b;
         return (p[47:40] != 8'd0) ? ScaleMax : p[39:16];
      end
   endfunction

   function automatic logic [15:0] sat16(input logic [40:0] v);
      return (v[40:16] != 25'd0) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic signed [COORD_BITS-1:0] satout(input logic signed [OBits:0] v);
      logic signed [OBits:0] hi;
      logic signed [OBits:0] r;
      begin
         hi = (OBits+1)'(CoordHi);
         if (v > hi) r = hi;
         else if (v < -hi - 1) r = -hi - 1;
         else r = v;
         return COORD_BITS'(r);
      end
   endfunction

   assign stat.last_step = (step_ff == 4'(CordicSteps - 1));

   logic [15:0] aq;
   assign aq = pang + 16'h2000;

   logic [15:0] pvx_c, pvy_c;
   assign pvx_c = sat16((41'(fw_ff) * 41'(rw_ff)) >> 16);
   assign pvy_c = sat16((41'(fh_ff) * 41'(rh_ff)) >> 16);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff <= IdBits'(node_id);
         par_ff <= IdBits'(parent_id);
         root_ff <= is_root;
         px_ff <= pos_x;
         py_ff <= pos_y;
         sw_ff <= own_scale_w;
         sh_ff <= own_scale_h;
         ang_ff <= local_angle;
         fw_ff <= center_frac_w;
         fh_ff <= center_frac_h;
         tw_ff <= texture_w;
         th_ff <= texture_h;
      end
      rd_ff <= table_mem[par_ff];
      if (cmd.compose) begin
         cw_ff <= root_ff ? sw_ff : mscale(pscw, sw_ff);
         ch_ff <= root_ff ? sh_ff : mscale(psch, sh_ff);
         fang_ff <= root_ff ? ang_ff : ang_ff + pang;
      end
      if (cmd.offset) begin
         dx_ff <= axis(porx, px_ff, cw_ff);
         dy_ff <= axis(pory, py_ff, ch_ff);
      end
      if (cmd.rot_init) begin
         // exact quarter turns, then gain
         case (aq[15:14])
            2'd0: begin
               x_ff <= RotBits'(dx_ff) * $signed({1'b0, CordicK});
               y_ff <= RotBits'(dy_ff) * $signed({1'b0, CordicK});
            end
            2'd1: begin
               x_ff <= -RotBits'(dy_ff) * $signed({1'b0, CordicK});
               y_ff <= RotBits'(dx_ff) * $signed({1'b0, CordicK});
            end
            2'd2: begin
               x_ff <= -RotBits'(dx_ff) * $signed({1'b0, CordicK});
               y_ff <= -RotBits'(dy_ff) * $signed({1'b0, CordicK});
            end
            default: begin
               x_ff <= RotBits'(dy_ff) * $signed({1'b0, CordicK});
               y_ff <= -RotBits'(dx_ff) * $signed({1'b0, CordicK});
            end
         endcase
         z_ff <= $signed({2'b00, aq[13:0], 16'd0}) - 32'sh2000_0000;
         step_ff <= '0;
      end
      if (cmd.rot_step) begin
         if (!z_ff[31]) begin
            x_ff <= x_ff - (y_ff >>> step_ff);
            y_ff <= y_ff + (x_ff >>> step_ff);
            z_ff <= z_ff - $signed(atan_entry(step_ff));
         end else begin
            x_ff <= x_ff + (y_ff >>> step_ff);
            y_ff <= y_ff - (x_ff >>> step_ff);
            z_ff <= z_ff + $signed(atan_entry(step_ff));
         end
         step_ff <= step_ff + 4'd1;
      end
      if (cmd.finish) begin
         ox_ff <= root_ff ? OBits'(px_ff) : OBits'(org(porx, x_ff));
         oy_ff <= root_ff ? OBits'(py_ff) : OBits'(org(pory, y_ff));
         rw_ff <= sat16((41'(cw_ff) * 41'(tw_ff)) >> 16);
         rh_ff <= sat16((41'(ch_ff) * 41'(th_ff)) >> 16);
      end
      if (cmd.commit) begin
         table_mem[id_ff] <= {cw_ff, ch_ff, fang_ff,
                              satout((OBits+1)'(ox_ff)),
                              satout((OBits+1)'(oy_ff))};
         rect_x <= 16'(satout((OBits+1)'(ox_ff) - (OBits+1)'($signed({1'b0, pvx_c}))));
         rect_y <= 16'(satout((OBits+1)'(oy_ff) - (OBits+1)'($signed({1'b0, pvy_c}))));
         rect_w <= rw_ff;
         rect_h <= rh_ff;
         render_angle <= fang_ff;
         pivot_x <= pvx_c;
         pivot_y <= pvy_c;
      end
   end
endmodule
`default_nettype wire

/* sv/hierarchical_sprite_transform_core.sv */
// Steps: read, compose, offset, quarter turns, 16 CORDIC steps, finish, commit.
// One request is in flight at a time; commit waits until the previous result is taken.
// A new request is taken once the prior result is in the output register.
// Reset clears the sequencer and output valid; node table is undefined until written.
`default_nettype none
module hierarchical_sprite_transform_core #(
   parameter int NODE_COUNT = hst_pkg::NodeCountDefault,
   parameter int COORD_BITS = hst_pkg::CoordBitsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // node_id[7:0] parent_id[15:8] pos_x[31:16] pos_y[47:32] own_scale_w[71:48]
   // own_scale_h[95:72] local_angle[111:96] center_frac_w[128:112]
   // center_frac_h[145:129] texture_w[159:146] texture_h[173:160], zero to 176
   input  wire logic [175:0] req_tdata,
   // is_root
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rect_x rect_y rect_w rect_h render_angle pivot_x pivot_y, 16 bits each
   output logic [111:0]      rsp_tdata
);
   import hst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   hst_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .stat
   );

   hst_dpath #(.NODE_COUNT(NODE_COUNT), .COORD_BITS(COORD_BITS)) u_dpath (
      .clock, .cmd, .stat,
      .node_id(req_tdata[7:0]), .parent_id(req_tdata[15:8]), .is_root(req_tuser),
      .pos_x(req_tdata[31:16]), .pos_y(req_tdata[47:32]),
      .own_scale_w(req_tdata[71:48]), .own_scale_h(req_tdata[95:72]),
      .local_angle(req_tdata[111:96]), .center_frac_w(req_tdata[128:112]),
      .center_frac_h(req_tdata[145:129]), .texture_w(req_tdata[159:146]),
      .texture_h(req_tdata[173:160]),
      .rect_x(rsp_tdata[15:0]), .rect_y(rsp_tdata[31:16]), .rect_w(rsp_tdata[47:32]),
      .rect_h(rsp_tdata[63:48]), .render_angle(rsp_tdata[79:64]),
      .pivot_x(rsp_tdata[95:80]), .pivot_y(rsp_tdata[111:96])
   );
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench of the hierarchical sprite transform core.
`default_nettype none
module testbench;
   import hst_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 60;

   typedef struct packed {
      logic [15:0] rect_x;
      logic [15:0] rect_y;
      logic [15:0] rect_w;
      logic [15:0] rect_h;
      logic [15:0] angle;
      logic [15:0] pivot_x;
      logic [15:0] pivot_y;
   } sprite_rect_type;

   typedef struct {
      logic [7:0]  node_id;
      logic [7:0]  parent_id;
      logic        is_root;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [23:0] scale_w;
      logic [23:0] scale_h;
      logic [15:0] angle;
      logic [16:0] frac_w;
      logic [16:0] frac_h;
      logic [13:0] tex_w;
      logic [13:0] tex_h;
   } sprite_node_type;

   class rect_scoreboard;
      sprite_rect_type pending[$];
      longint       tbl_scale_w[256];
      longint       tbl_scale_h[256];
      longint       tbl_angle[256];
      longint       tbl_org_x[256];
      longint       tbl_org_y[256];
      int           mismatches;

      function longint floor_shr(longint v, int k);
         return v >>> k;
      endfunction

      function longint clamp_coord(longint v);
         return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
      endfunction

      function longint clamp_u16(longint v);
         return v > 65535 ? 65535 : v;
      endfunction

      function longint trunc_q16(longint v);
         // truncate toward zero
         return v < 0 ? -((-v) >> 16) : (v >> 16);
      endfunction

      function void note_request(sprite_node_type n);
         longint sw, sh, ang, ox, oy, pox, poy, dx, dy, x, y, z, t, xs, ys;
         longint rw, rh, pvx, pvy;
         int     q;
         sprite_rect_type r;
         sw = n.scale_w;
         sh = n.scale_h;
         ang = n.angle;
         if (!n.is_root) begin
            sw = (tbl_scale_w[n.parent_id] * sw) >> 16;
            sh = (tbl_scale_h[n.parent_id] * sh) >> 16;
            if (sw > ScaleMax) sw = ScaleMax;
            if (sh > ScaleMax) sh = ScaleMax;
            pox = tbl_org_x[n.parent_id];
            poy = tbl_org_y[n.parent_id];
            dx = trunc_q16(pox * 65536 + longint'($signed(n.pos_x)) * sw) - pox;
            dy = trunc_q16(poy * 65536 + longint'($signed(n.pos_y)) * sh) - poy;
            x = dx;
            y = dy;
            q = int'(((tbl_angle[n.parent_id] + 'h2000) >> 14) & 3);
            for (int i = 0; i < q; i++) begin
               t = x;
               x = -y;
               y = t;
            end
            z = ((((tbl_angle[n.parent_id] + 'h2000)) & 'h3FFF) - 'h2000) * 65536;
            x = x * CordicK;
            y = y * CordicK;
            for (int i = 0; i < CordicSteps; i++) begin
               xs = floor_shr(x, i);
               ys = floor_shr(y, i);
               if (z >= 0) begin
                  x = x - ys;
                  y = y + xs;
                  z = z - atan_entry(4'(i));
               end else begin
                  x = x + ys;
                  y = y - xs;
                  z = z + atan_entry(4'(i));
               end
            end
            ox = trunc_q16(pox * 65536 + x);
            oy = trunc_q16(poy * 65536 + y);
            ang = (ang + tbl_angle[n.parent_id]) & 'hFFFF;
         end else begin
            ox = longint'($signed(n.pos_x));
            oy = longint'($signed(n.pos_y));
         end
         rw = clamp_u16((sw * n.tex_w) >> 16);
         rh = clamp_u16((sh * n.tex_h) >> 16);
         pvx = clamp_u16((n.frac_w * rw) >> 16);
         pvy = clamp_u16((n.frac_h * rh) >> 16);
         ox = clamp_coord(ox);
         oy = clamp_coord(oy);
         tbl_scale_w[n.node_id] = sw;
         tbl_scale_h[n.node_id] = sh;
         tbl_angle[n.node_id] = ang;
         tbl_org_x[n.node_id] = ox;
         tbl_org_y[n.node_id] = oy;
         r.rect_x = 16'(clamp_coord(ox - pvx));
         r.rect_y = 16'(clamp_coord(oy - pvy));
         r.rect_w = 16'(rw);
         r.rect_h = 16'(rh);
         r.angle = 16'(ang);
         r.pivot_x = 16'(pvx);
         r.pivot_y = 16'(pvy);
         pending.push_back(r);
      endfunction

      function void check_rect(logic [111:0] d);
         sprite_rect_type got, want;
         got.rect_x = d[15:0];
         got.rect_y = d[31:16];
         got.rect_w = d[47:32];
         got.rect_h = d[63:48];
         got.angle = d[79:64];
         got.pivot_x = d[95:80];
         got.pivot_y = d[111:96];
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", d);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected x=%0d y=%0d w=%0d h=%0d a=%0d px=%0d py=%0d",
                        $signed(want.rect_x), $signed(want.rect_y), want.rect_w,
                        want.rect_h, want.angle, want.pivot_x, want.pivot_y,
                        "\n          actual   x=%0d y=%0d w=%0d h=%0d a=%0d px=%0d py=%0d",
                        $signed(got.rect_x), $signed(got.rect_y), got.rect_w,
                        got.rect_h, got.angle, got.pivot_x, got.pivot_y);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;

   rect_scoreboard sb = new();
   bit   written[256];
   int   idle_cycles;
   bit   quiet_phase;
   bit   hold_off;

   hierarchical_sprite_transform_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit idle_now();
      return !quiet_phase && $urandom_range(99) < 8;
   endfunction

   // send one request; the node table is updated once it is accepted
   task automatic send_node(sprite_node_type n);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= n.is_root;
      req_tdata <= {2'b0, n.tex_h, n.tex_w, n.frac_h, n.frac_w, n.angle, n.scale_h,
                    n.scale_w, n.pos_y, n.pos_x, n.parent_id, n.node_id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(n);
      written[n.node_id] = 1'b1;
   endtask

   function automatic sprite_node_type random_node(bit well_formed);
      sprite_node_type n;
      int           pick;
      n.node_id = 8'($urandom);
      n.parent_id = 8'($urandom);
      n.is_root = $urandom_range(9) == 0;
      if (!written[n.parent_id]) n.is_root = 1'b1;
      pick = $urandom_range(3);
      n.pos_x = pick == 0 ? 16'($urandom) : 16'($signed($urandom_range(400)) - 200);
      n.pos_y = pick == 0 ? 16'($urandom) : 16'($signed($urandom_range(400)) - 200);
      n.scale_w = well_formed ? 24'($urandom_range('h20000, 'h4000)) : 24'($urandom);
      n.scale_h = well_formed ? 24'($urandom_range('h20000, 'h4000)) : 24'($urandom);
      n.angle = 16'($urandom);
      n.frac_w = 17'($urandom_range(65536));
      n.frac_h = 17'($urandom_range(65536));
      n.tex_w = well_formed ? 14'($urandom_range(1, 512)) : 14'($urandom);
      n.tex_h = well_formed ? 14'($urandom_range(1, 512)) : 14'($urandom);
      return n;
   endfunction

   function automatic sprite_node_type make_node(logic [7:0] id, logic [7:0] par, bit root,
                                              logic [15:0] px, logic [15:0] py,
                                              logic [23:0] s, logic [15:0] a,
                                              logic [16:0] f, logic [13:0] tx);
      sprite_node_type n;
      n.node_id = id;
      n.parent_id = par;
      n.is_root = root;
      n.pos_x = px;
      n.pos_y = py;
      n.scale_w = s;
      n.scale_h = s;
      n.angle = a;
      n.frac_w = f;
      n.frac_h = f;
      n.tex_w = tx;
      n.tex_h = tx;
      return n;
   endfunction

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // response side
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= !hold_off && !idle_now();
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_rect(rsp_tdata);
      end
   end

   // watchdog: reset count on any accepted transfer
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      sprite_node_type n;
      quiet_phase = 1'b0;
      hold_off = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: roots at extremes, then children of them
      send_node(make_node(8'd0, 8'd0, 1'b1, 16'h7FFF, 16'h8000, 24'hFFFFFF, 16'hFFFF,
                          17'd65536, 14'd8192));
      send_node(make_node(8'd1, 8'd0, 1'b1, 16'h8000, 16'h7FFF, 24'h000000, 16'h0000,
                          17'd0, 14'd1));
      send_node(make_node(8'd2, 8'd0, 1'b1, 16'd100, 16'd50, 24'h010000, 16'h2000,
                          17'd32768, 14'd64));
      send_node(make_node(8'd3, 8'd2, 1'b0, 16'd10, -16'sd20, 24'h018000, 16'h1FFF,
                          17'd65536, 14'd100));
      send_node(make_node(8'd4, 8'd3, 1'b0, -16'sd30, 16'd40, 24'h008000, 16'h4000,
                          17'd1000, 14'd200));
      send_node(make_node(8'd4, 8'd4, 1'b0, 16'd5, 16'd5, 24'h010000, 16'h8000,
                          17'd20000, 14'd50));
      send_node(make_node(8'd5, 8'd0, 1'b0, 16'h7FFF, 16'h8000, 24'hFFFFFF, 16'hC000,
                          17'd65536, 14'd8192));
      send_node(make_node(8'd6, 8'd1, 1'b0, 16'd300, 16'd300, 24'hFFFFFF, 16'hE000,
                          17'd65536, 14'd0));
      send_node(make_node(8'd7, 8'd2, 1'b0, 16'h8000, 16'h8000, 24'h100000, 16'h6000,
                          17'd1, 14'd8191));
      send_node(make_node(8'd255, 8'd3, 1'b0, 16'h7FFF, 16'h7FFF, 24'h020000, 16'hA000,
                          17'h1FFFF, 14'h3FFF));
      send_node(make_node(8'd8, 8'd255, 1'b0, -16'sd1, -16'sd1, 24'h00FFFF, 16'hDFFF,
                          17'd65535, 14'd1));

      // random with a quiet stretch, a long receiver hold-off and a full drain
      for (int i = 0; i < 950; i++) begin
         quiet_phase = i >= 300 && i < 420;
         if (i == 500) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (200) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         if (i == 700) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         n = random_node($urandom_range(9) != 0);
         send_node(n);
      end
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* hierarchical_sprite_transform_core.f */
sv/hst_pkg.sv
sv/hst_ctrl.sv
sv/hst_dpath.sv
sv/hierarchical_sprite_transform_core.sv
dv/testbench.sv
